// ===== hw/rtl/rgb_led_frame_editor_unit_assert.svh =====
// Assertion macros used by the top level of the LED frame editor RTL.
`ifndef RGB_LED_FRAME_EDITOR_UNIT_ASSERT_SVH
`define RGB_LED_FRAME_EDITOR_UNIT_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define RLFE_ASSERT_NOW(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("rlfe: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define RLFE_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("rlfe: next-cycle check failed");

`endif

// ===== hw/rtl/rlfe_pkg.sv =====
// Package with the types and constants of the LED frame editor.
`default_nettype none

package rlfe_pkg;

  // Strip geometry.
  localparam int LedCount   = 3;
  localparam int Channels   = 3;
  localparam int StartBytes = 4;
  localparam int EndBytes   = 4;
  localparam int FrameLen   = StartBytes + 4 * LedCount + EndBytes;
  localparam int LedEnd     = StartBytes + 4 * LedCount;

  localparam int LED_W = (LedCount > 1) ? $clog2(LedCount) : 1;
  localparam int CH_W  = 2;
  localparam int CNT_W = $clog2(FrameLen);
  localparam int BRT_W = 5;

  // Fixed frame bytes.
  localparam logic [7:0]       BYTE_START = 8'h00;
  localparam logic [7:0]       BYTE_END   = 8'hFF;
  localparam logic [2:0]       HDR_MARK   = 3'b111;
  localparam logic [BRT_W-1:0] BRT_RESET  = 5'd31;

  // Channel codes inside the colour store.
  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

  // Position of a byte inside one LED's four-byte group.
  localparam logic [1:0] SLOT_HDR   = 2'd0;
  localparam logic [1:0] SLOT_BLUE  = 2'd1;
  localparam logic [1:0] SLOT_GREEN = 2'd2;
  localparam logic [1:0] SLOT_RED   = 2'd3;

  typedef enum logic [1:0] {
    REQ_LEVEL    = 2'd0,
    REQ_NEXT_CH  = 2'd1,
    REQ_NEXT_LED = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_SEND
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic apply;    // update store and selection from the accepted request
    logic clr_cnt;  // restart the frame byte counter
    logic load;     // load the next frame byte into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_last; // output register holds the final frame byte
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rlfe_ctrl.sv =====
// Controller state machine of the LED frame editor.
`default_nettype none

module rlfe_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire rlfe_pkg::dp_sts_t sts_i,
  output rlfe_pkg::dp_cmd_t     cmd_o
);
  import rlfe_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FILL;
      end
      ST_FILL: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready_i && sts_i.out_last) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.apply   = in_valid_i;
        cmd_o.clr_cnt = in_valid_i;
      end
      ST_FILL: begin
        cmd_o.load = 1'b1;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        cmd_o.load  = out_ready_i && !sts_i.out_last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rlfe_dp.sv =====
// Datapath of the LED frame editor: colour store, selection and frame byte generator.
`default_nettype none

module rlfe_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire rlfe_pkg::dp_cmd_t         cmd_i,
  output rlfe_pkg::dp_sts_t              sts_o,
  input  wire logic [1:0]                req_type_i,
  input  wire logic [7:0]                level_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [rlfe_pkg::BRT_W-1:0] cfg_wdata_i,
  output logic [7:0]                     frame_byte_o,
  output logic                           frame_last_o
);
  import rlfe_pkg::*;

  logic [7:0]       store_q [LedCount][Channels];
  logic [7:0]       store_d [LedCount][Channels];
  logic [LED_W-1:0] sel_led_q, sel_led_d;
  logic [CH_W-1:0]  sel_ch_q, sel_ch_d;
  logic [BRT_W-1:0] brt_q, brt_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  logic [CNT_W-1:0] off;
  logic [LED_W-1:0] led_idx;
  logic [1:0]       slot;
  logic [7:0]       next_byte;
  logic             next_last;

  // Request handling: level write or selection step.
  always_comb begin
    store_d   = store_q;
    sel_led_d = sel_led_q;
    sel_ch_d  = sel_ch_q;
    if (cmd_i.apply) begin
      case (req_e'(req_type_i))
        REQ_LEVEL: begin
          store_d[sel_led_q][sel_ch_q] = level_i;
        end
        REQ_NEXT_CH: begin
          sel_ch_d = (sel_ch_q == CH_BLUE) ? CH_RED : sel_ch_q + 1'b1;
        end
        REQ_NEXT_LED: begin
          sel_led_d = (sel_led_q == LED_W'(LedCount - 1)) ? '0 : sel_led_q + 1'b1;
          sel_ch_d  = CH_RED;
        end
        default: begin
          sel_ch_d = sel_ch_q;
        end
      endcase
    end
  end

  assign brt_d = cfg_we_i ? cfg_wdata_i : brt_q;

  // Frame byte for the current counter position.
  assign off     = cnt_q - CNT_W'(StartBytes);
  assign led_idx = LED_W'(off >> 2);
  assign slot    = off[1:0];

  always_comb begin
    next_byte = BYTE_START;
    next_last = 1'b0;
    if (cnt_q < CNT_W'(StartBytes)) begin
      next_byte = BYTE_START;
    end else if (cnt_q >= CNT_W'(LedEnd)) begin
      next_byte = BYTE_END;
      next_last = (cnt_q == CNT_W'(FrameLen - 1));
    end else begin
      case (slot)
        SLOT_HDR:   next_byte = {HDR_MARK, brt_q};
        SLOT_BLUE:  next_byte = store_q[led_idx][CH_BLUE];
        SLOT_GREEN: next_byte = store_q[led_idx][CH_GREEN];
        SLOT_RED:   next_byte = store_q[led_idx][CH_RED];
        default:    next_byte = BYTE_START;
      endcase
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    if (cmd_i.clr_cnt) begin
      cnt_d = '0;
    end else if (cmd_i.load) begin
      cnt_d      = cnt_q + 1'b1;
      out_byte_d = next_byte;
      out_last_d = next_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LedCount; l++) begin
        for (int c = 0; c < Channels; c++) begin
          store_q[l][c] <= '0;
        end
      end
      sel_led_q  <= '0;
      sel_ch_q   <= CH_RED;
      brt_q      <= BRT_RESET;
      cnt_q      <= '0;
      out_last_q <= 1'b0;
    end else begin
      store_q    <= store_d;
      sel_led_q  <= sel_led_d;
      sel_ch_q   <= sel_ch_d;
      brt_q      <= brt_d;
      cnt_q      <= cnt_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
  end

  assign sts_o.out_last = out_last_q;
  assign frame_byte_o   = out_byte_q;
  assign frame_last_o   = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_led_frame_editor_unit.sv =====
// Top level of the LED frame editor: an editable colour store that streams strip frames.
//
// Usage: each request on the slave stream edits the colour store and then triggers one
// complete strip frame on the master stream. tuser carries the request kind (level
// sample, next colour channel, next LED); tdata carries the level. The frame is four
// 0x00 bytes, a header (0xE0 | brightness) with blue, green and red bytes for each LED,
// then four 0xFF bytes; tlast marks the final 0xFF byte.
// Once a request is accepted, the controller loads the first frame byte into the output
// register in its fill state and offers it in its send state.
// Throughput: one byte per cycle while the receiver keeps tready high. The controller
// handles one request at a time; the byte counter in the datapath sets the frame length.
// Stalls: when tready is low the output register holds its byte and tlast, and no
// new request is taken until the final byte of the frame has been accepted.
// Reset: the colour store and the selected LED and channel are cleared, the brightness
// returns to 31, and the block waits for a request. The brightness register is written
// through cfg_we_i / cfg_wdata_i by the user only while idle; the block does not check.
`default_nettype none

`include "rgb_led_frame_editor_unit_assert.svh"

module rgb_led_frame_editor_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rlfe_pkg::BRT_W-1:0]  cfg_wdata_i,   // global_brightness
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [7:0] level_sample
  input  wire logic [1:0]                  s_axis_tuser,  // [1:0] req_type
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [7:0] frame_byte
  output logic                             m_axis_tlast   // frame_last
);
  import rlfe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences accept, first load and the byte stream.
  rlfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the colour store, the selection and the output register.
  rlfe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (s_axis_tuser),
    .level_i      (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .frame_byte_o (m_axis_tdata),
    .frame_last_o (m_axis_tlast)
  );

  // A request is never taken while a frame byte is on offer.
  `RLFE_ASSERT_NOW(a_no_accept_while_sending, clk_i, rst_ni,
                   s_axis_tready, !m_axis_tvalid)

  // After a request is accepted the block is busy for at least the next cycle.
  `RLFE_ASSERT_NEXT(a_busy_after_request, clk_i, rst_ni,
                    s_axis_tvalid && s_axis_tready, !s_axis_tready && cmd.load)

  // Once the final byte of a frame is taken, the block is ready for a new request.
  `RLFE_ASSERT_NEXT(a_ready_after_last, clk_i, rst_ni,
                    m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)

endmodule

`default_nettype wire

// ===== bench/rgb_led_frame_editor_unit_test.sv =====
// Self-checking testbench for the LED frame editor: colour edits in, strip frames out.
`default_nettype none

module rgb_led_frame_editor_unit_test;
  import rlfe_pkg::*;

  // The request kind that the block has no use for. It must leave the state alone and
  // still produce a frame.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // The watchdog gives up after this many cycles in which nothing is accepted on any
  // side. The longest deliberate silence is the receiver hold-off below.
  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 150;
  localparam int TailCycles = 6;
  localparam int MaxReports = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [BRT_W-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;   // [7:0] level_sample
  logic [1:0]          s_axis_tuser  = '0;   // [1:0] req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;         // [7:0] frame_byte
  logic                m_axis_tlast;         // frame_last

  rgb_led_frame_editor_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Our own copy of the editor state, updated as requests are accepted.
  logic [7:0]       led_levels [LedCount][Channels];
  logic [LED_W-1:0] sel_led;
  logic [CH_W-1:0]  sel_channel;
  logic [BRT_W-1:0] brightness;

  // Frame bytes that the block still owes us, oldest first.
  frame_byte_t frame_bytes_due[$];

  // Idle chances in percent per cycle, and a one-shot request for a long output stall.
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_request      = 0;

  int error_count       = 0;
  int quiet_cycles      = 0;
  int bytes_checked     = 0;
  int frames_checked    = 0;
  int brightness_writes = 0;
  int requests_by_kind [4] = '{default: 0};

  task automatic report_mismatch(input string what);
    if (error_count < MaxReports) begin
      $display("%0t: mismatch: %s", $realtime, what);
    end
    error_count++;
  endtask

  // Applies one accepted request to the local state, then queues the whole frame that
  // the block must send for it. Samples on any kind but a level sample are ignored.
  function automatic void edit_and_queue_frame(input logic [1:0] kind,
                                               input logic [7:0] level);
    frame_byte_t fb;
    if (kind == REQ_LEVEL) begin
      led_levels[sel_led][sel_channel] = level;
    end else if (kind == REQ_NEXT_CH) begin
      sel_channel = (sel_channel == CH_BLUE) ? CH_RED : sel_channel + 1'b1;
    end else if (kind == REQ_NEXT_LED) begin
      sel_led     = (sel_led == LED_W'(LedCount - 1)) ? '0 : sel_led + 1'b1;
      sel_channel = CH_RED;
    end
    // Start bytes, then header, blue, green and red per LED, then end bytes.
    for (int i = 0; i < StartBytes; i++) begin
      fb = '{data: BYTE_START, last: 1'b0};
      frame_bytes_due.push_back(fb);
    end
    for (int led = 0; led < LedCount; led++) begin
      fb = '{data: {HDR_MARK, brightness}, last: 1'b0};
      frame_bytes_due.push_back(fb);
      fb = '{data: led_levels[led][CH_BLUE], last: 1'b0};
      frame_bytes_due.push_back(fb);
      fb = '{data: led_levels[led][CH_GREEN], last: 1'b0};
      frame_bytes_due.push_back(fb);
      fb = '{data: led_levels[led][CH_RED], last: 1'b0};
      frame_bytes_due.push_back(fb);
    end
    for (int i = 0; i < EndBytes; i++) begin
      fb = '{data: BYTE_END, last: (i == EndBytes - 1)};
      frame_bytes_due.push_back(fb);
    end
  endfunction

  // Everything that happens at a clock edge is observed here, from the values that held
  // just before the edge: the model follows accepted requests and brightness writes, and
  // every accepted frame byte is checked against the oldest one owed. Output is checked
  // before a new request is predicted, so a byte never meets a frame queued at its edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int led = 0; led < LedCount; led++) begin
        for (int ch = 0; ch < Channels; ch++) begin
          led_levels[led][ch] = '0;
        end
      end
      sel_led      = '0;
      sel_channel  = CH_RED;
      brightness   = BRT_RESET;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        if (frame_bytes_due.size() == 0) begin
          report_mismatch($sformatf("frame byte %02h with none expected", m_axis_tdata));
        end else begin
          if (m_axis_tdata !== frame_bytes_due[0].data) begin
            report_mismatch($sformatf("frame byte %02h, expected %02h",
                                      m_axis_tdata, frame_bytes_due[0].data));
          end
          if (m_axis_tlast !== frame_bytes_due[0].last) begin
            report_mismatch($sformatf("frame last %b, expected %b on byte %02h",
                                      m_axis_tlast, frame_bytes_due[0].last,
                                      frame_bytes_due[0].data));
          end
          if (frame_bytes_due[0].last) begin
            frames_checked++;
          end
          void'(frame_bytes_due.pop_front());
          bytes_checked++;
        end
      end
      if (cfg_we_i) begin
        brightness = cfg_wdata_i;
        brightness_writes++;
        quiet_cycles = 0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        quiet_cycles = 0;
        requests_by_kind[s_axis_tuser]++;
        edit_and_queue_frame(s_axis_tuser, s_axis_tdata);
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: %0d cycles without a transfer", quiet_cycles);
        $display("rgb_led_frame_editor_unit_test NOT OK");
        $finish;
      end
    end
  end

  // Receiver side. A hold-off request keeps tready low for that many cycles, counted
  // here; otherwise tready drops at random with the current idle chance.
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Offers one request and returns at the edge where it is taken. tvalid is only dropped
  // when the sender actually idles, so back-to-back requests keep it high throughout.
  task automatic send_edit(input logic [1:0] kind, input logic [7:0] level);
    logic lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      if (!lowered) begin
        s_axis_tvalid <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk_i);
    end
    s_axis_tuser  <= kind;
    s_axis_tdata  <= level;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Stops offering requests and waits until every owed frame byte has come out. The
  // first edge lets the checker pick up a request taken at the edge we returned on.
  task automatic wait_for_frames();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
  endtask

  // The block must be idle here; the checker picks up the new value at the edge.
  task automatic write_brightness(input logic [BRT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Walks the selection through every channel and LED with wraps on both, writes the
  // extreme levels, and sends samples that must be ignored, including one on the unused
  // request kind straight out of reset.
  task automatic test_directed_edits();
    send_edit(REQ_UNUSED,   8'hFF);
    send_edit(REQ_LEVEL,    8'hFF);
    send_edit(REQ_NEXT_CH,  8'h55);
    send_edit(REQ_LEVEL,    8'h00);
    send_edit(REQ_NEXT_CH,  8'hAA);
    send_edit(REQ_LEVEL,    8'hA5);
    send_edit(REQ_NEXT_CH,  8'h00);   // blue wraps back to red
    send_edit(REQ_LEVEL,    8'h5A);
    send_edit(REQ_NEXT_LED, 8'hFF);
    send_edit(REQ_NEXT_CH,  8'h0F);
    send_edit(REQ_NEXT_CH,  8'hF0);
    send_edit(REQ_LEVEL,    8'h7E);
    send_edit(REQ_NEXT_LED, 8'h33);   // channel must return to red
    send_edit(REQ_LEVEL,    8'h01);
    send_edit(REQ_NEXT_LED, 8'h00);   // last LED wraps to the first
    send_edit(REQ_LEVEL,    8'h80);
    send_edit(REQ_UNUSED,   8'h12);
    wait_for_frames();
  endtask

  // Both brightness extremes and a mixed bit pattern, each seen in the LED headers.
  task automatic test_brightness_extremes();
    write_brightness('0);
    send_edit(REQ_UNUSED, 8'h00);
    send_edit(REQ_LEVEL,  8'hC3);
    wait_for_frames();
    write_brightness(5'h15);
    send_edit(REQ_NEXT_CH, 8'h3C);
    wait_for_frames();
    write_brightness('1);
    send_edit(REQ_NEXT_LED, 8'h99);
    wait_for_frames();
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the block has
  // to hold its output byte and refuse input; then the sender waits for a full drain.
  task automatic test_output_stall();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_request      = HoldCycles;
    repeat (6) send_edit(2'($urandom_range(3)), 8'($urandom_range(255)));
    wait_for_frames();
  endtask

  // Random editing. Most requests are level samples and selection moves, as a user
  // editing colours would send; a few are the unused kind. Levels are random on every
  // kind so ignored samples are covered too.
  task automatic test_random_edits(input int tx_idle, input int rx_idle, input int count);
    int          pick;
    logic [1:0]  kind;
    sender_idle_pct   = tx_idle;
    receiver_idle_pct = rx_idle;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        kind = REQ_LEVEL;
      end else if (pick < 75) begin
        kind = REQ_NEXT_CH;
      end else if (pick < 92) begin
        kind = REQ_NEXT_LED;
      end else begin
        kind = REQ_UNUSED;
      end
      send_edit(kind, 8'($urandom_range(255)));
    end
    wait_for_frames();
    write_brightness(BRT_W'($urandom_range(31)));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edits();
    test_brightness_extremes();
    test_output_stall();
    test_random_edits(11, 54, 42);
    test_random_edits(54, 11, 42);
    test_random_edits(0, 0, 42);

    wait_for_frames();
    repeat (TailCycles) @(posedge clk_i);
    if (frame_bytes_due.size() != 0) begin
      report_mismatch($sformatf("%0d frame bytes never sent", frame_bytes_due.size()));
    end

    $display("covered: %0d level samples, %0d channel steps, %0d LED steps, %0d unused",
             requests_by_kind[REQ_LEVEL], requests_by_kind[REQ_NEXT_CH],
             requests_by_kind[REQ_NEXT_LED], requests_by_kind[REQ_UNUSED]);
    $display("checked %0d frames (%0d bytes) over %0d brightness settings, %0d errors",
             frames_checked, bytes_checked, brightness_writes, error_count);
    if (error_count == 0) begin
      $display("rgb_led_frame_editor_unit_test OK");
    end else begin
      $display("rgb_led_frame_editor_unit_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rlfe_pkg.sv
hw/rtl/rlfe_ctrl.sv
hw/rtl/rlfe_dp.sv
hw/rtl/rgb_led_frame_editor_unit.sv
bench/rgb_led_frame_editor_unit_test.sv
